@@ rtl/bpd_pkg.sv @@
`default_nettype none

package bpd_pkg;

  // Field widths of the item and result channels
  localparam int KIND_W  = 2;
  localparam int POS_W   = 16;
  localparam int INDEX_W = 13;
  localparam int SUM_W   = 40;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_DEPOSIT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCALE,
    ST_BASE,
    ST_RUN,
    ST_DRAIN,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bilinear_particle_deposit.sv @@
`default_nettype none

// Cloud-in-cell deposition of particles onto a (CELLS_X+1) x (CELLS_Y+1) point grid.
// Input channel (in_valid/in_ready): one item per transfer. A deposit item (kind 0)
// adds the four bilinear corner weights of its particle into the grid sums and returns
// nothing; a void particle or kind 3 is dropped. A read item (kind 1) or read-and-clear
// item (kind 2) returns one result on the output channel (out_valid/out_ready).
// Timing: the block takes one item at a time. A deposit keeps the input closed after
// its transfer through scale, base address, four read-modify-write slots on the
// grid memory and one write drain, and only then takes the next item.
// A read passes through the grid memory read register and then the output register,
// and the input reopens in the same cycle the result is registered.
// The grid memory allows one read and one write per cycle; the corner loop through it
// sets how long a deposit keeps the input closed.
// Reset: a clearing pass writes zero to every grid point, one point per cycle, over all
// (CELLS_X+1)*(CELLS_Y+1) points (4225 at the default size); in_ready stays low meanwhile.
// Stall: while a result waits in the output register, a new read item is still taken;
// its result is held back and in_ready stays low until the output register frees up.
module bilinear_particle_deposit #(
  parameter int CELLS_X  = 64,
  parameter int CELLS_Y  = 64,
  parameter int POS_BITS = 16,
  parameter int ACC_BITS = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bpd_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [bpd_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic [bpd_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic                         in_is_void,
  input  wire logic [bpd_pkg::INDEX_W-1:0]  in_point_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [bpd_pkg::INDEX_W-1:0]       out_read_index,
  output logic [bpd_pkg::SUM_W-1:0]         out_point_sum,
  output logic                              out_was_saturated
);

  localparam int FRAC    = ACC_BITS / 2;
  localparam int PTS_X   = CELLS_X + 1;
  localparam int NPOINTS = PTS_X * (CELLS_Y + 1);
  localparam int ADDR_W  = $clog2(NPOINTS);
  localparam int MEM_W   = ACC_BITS + 1;
  localparam int CXI_W   = $clog2(CELLS_X);
  localparam int CYI_W   = $clog2(CELLS_Y);
  localparam int SX_W    = POS_BITS + $clog2(CELLS_X + 1);
  localparam int SY_W    = POS_BITS + $clog2(CELLS_Y + 1);
  localparam int MUL_W   = 2 * POS_BITS + 2;
  localparam int SHIFT   = 2 * POS_BITS - FRAC;
  localparam int LSH     = (SHIFT < 0) ? -SHIFT : 0;
  localparam int RSH     = (SHIFT > 0) ? SHIFT : 0;
  localparam int EXT_W   = MUL_W + LSH;
  localparam int W_W     = FRAC + 1;
  localparam int CMP_W   = ((ADDR_W > bpd_pkg::INDEX_W) ? ADDR_W : bpd_pkg::INDEX_W) + 1;

  localparam logic [ACC_BITS-1:0] ACC_MAX     = '1;
  localparam logic [1:0]          CORNER_LAST = 2'd3;

  bpd_pkg::state_t state_r, state_nxt;

  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [1:0]          k_r;
  logic                out_valid_r;

  logic [POS_BITS-1:0] px_r, py_r;
  logic [CXI_W-1:0]    ci_r;
  logic [CYI_W-1:0]    cj_r;
  logic [POS_BITS-1:0] fx_r, fy_r;
  logic [ADDR_W-1:0]   base_r;
  logic [MUL_W-1:0]    mul_r;
  logic [ADDR_W-1:0]   wr_corner_r;
  logic                rd_clear_r;
  logic                rd_in_range_r;
  logic [bpd_pkg::INDEX_W-1:0] rd_index_r;

  logic [bpd_pkg::INDEX_W-1:0] out_read_index_r;
  logic [bpd_pkg::SUM_W-1:0]   out_point_sum_r;
  logic                        out_was_saturated_r;

  logic [MEM_W-1:0] grid_r [NPOINTS];
  logic [MEM_W-1:0] rd_data_r;

  logic                in_acc;
  logic                is_read_kind;
  logic                in_range;
  logic [SX_W-1:0]     sx;
  logic [SY_W-1:0]     sy;
  logic [POS_BITS:0]   ux, uy, mul_a, mul_b;
  logic [ADDR_W-1:0]   corner_addr;
  logic [EXT_W-1:0]    weight_ext;
  logic [W_W-1:0]      weight;
  logic [ACC_BITS:0]   sum_ext;
  logic [ACC_BITS-1:0] acc_sum;
  logic                acc_sat;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [MEM_W-1:0]    wr_data;
  logic                out_load;

  // ---------------------------------------------------------------- datapath
  assign in_acc       = in_valid && in_ready;
  assign is_read_kind = (in_kind == bpd_pkg::KIND_READ) || (in_kind == bpd_pkg::KIND_READ_CLEAR);
  assign in_range     = CMP_W'(in_point_index) < CMP_W'(NPOINTS);

  // Scale positions by the cell counts: high part is the cell, low part the fraction
  assign sx = SX_W'(px_r) * SX_W'(CELLS_X);
  assign sy = SY_W'(py_r) * SY_W'(CELLS_Y);

  // Complementary fractions, one cell minus the fraction
  assign ux = {1'b1, {POS_BITS{1'b0}}} - {1'b0, fx_r};
  assign uy = {1'b1, {POS_BITS{1'b0}}} - {1'b0, fy_r};

  // Corner order: (i,j), (i+1,j), (i,j+1), (i+1,j+1); bit 0 steps x, bit 1 steps y
  assign mul_a       = k_r[0] ? {1'b0, fx_r} : ux;
  assign mul_b       = k_r[1] ? {1'b0, fy_r} : uy;
  assign corner_addr = base_r + ADDR_W'(k_r[0]) + (k_r[1] ? ADDR_W'(PTS_X) : '0);

  // Convert the product to FRAC fraction bits by truncation
  assign weight_ext = EXT_W'(mul_r) << LSH;
  assign weight     = W_W'(weight_ext >> RSH);

  // Saturating accumulate; the flag sticks once the sum reaches the maximum
  assign sum_ext = {1'b0, rd_data_r[ACC_BITS-1:0]} + (ACC_BITS + 1)'(weight);
  assign acc_sum = sum_ext[ACC_BITS] ? ACC_MAX : sum_ext[ACC_BITS-1:0];
  assign acc_sat = rd_data_r[ACC_BITS] || (acc_sum == ACC_MAX);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpd_pkg::ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(NPOINTS - 1)) state_nxt = bpd_pkg::ST_IDLE;
      end
      bpd_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (in_kind == bpd_pkg::KIND_DEPOSIT && !in_is_void) begin
            state_nxt = bpd_pkg::ST_SCALE;
          end else if (is_read_kind) begin
            state_nxt = bpd_pkg::ST_READ;
          end else begin
            state_nxt = bpd_pkg::ST_IDLE;
          end
        end
      end
      bpd_pkg::ST_SCALE: state_nxt = bpd_pkg::ST_BASE;
      bpd_pkg::ST_BASE:  state_nxt = bpd_pkg::ST_RUN;
      bpd_pkg::ST_RUN: begin
        if (k_r == CORNER_LAST) state_nxt = bpd_pkg::ST_DRAIN;
      end
      bpd_pkg::ST_DRAIN: state_nxt = bpd_pkg::ST_IDLE;
      bpd_pkg::ST_READ: begin
        if (!out_valid_r || out_ready) state_nxt = bpd_pkg::ST_IDLE;
      end
      default: state_nxt = bpd_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = corner_addr;
    wr_en    = 1'b0;
    wr_addr  = clr_cnt_r;
    wr_data  = '0;
    out_load = 1'b0;
    unique case (state_r)
      bpd_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
      end
      bpd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid && is_read_kind;
        rd_addr  = ADDR_W'(in_point_index);
      end
      bpd_pkg::ST_RUN: begin
        // Read this corner, write back the one read in the previous cycle
        rd_en = 1'b1;
        if (k_r != 2'd0) begin
          wr_en   = 1'b1;
          wr_addr = wr_corner_r;
          wr_data = {acc_sat, acc_sum};
        end
      end
      bpd_pkg::ST_DRAIN: begin
        wr_en   = 1'b1;
        wr_addr = wr_corner_r;
        wr_data = {acc_sat, acc_sum};
      end
      bpd_pkg::ST_READ: begin
        out_load = !out_valid_r || out_ready;
        wr_en    = out_load && rd_clear_r && rd_in_range_r;
        wr_addr  = ADDR_W'(rd_index_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpd_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bpd_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (state_r == bpd_pkg::ST_BASE) begin
        k_r <= 2'd0;
      end else if (state_r == bpd_pkg::ST_RUN) begin
        k_r <= k_r + 2'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r          <= POS_BITS'(in_pos_x);
      py_r          <= POS_BITS'(in_pos_y);
      rd_index_r    <= in_point_index;
      rd_clear_r    <= (in_kind == bpd_pkg::KIND_READ_CLEAR);
      rd_in_range_r <= in_range;
    end
    if (state_r == bpd_pkg::ST_SCALE) begin
      ci_r <= sx[POS_BITS +: CXI_W];
      cj_r <= sy[POS_BITS +: CYI_W];
      fx_r <= sx[POS_BITS-1:0];
      fy_r <= sy[POS_BITS-1:0];
    end
    if (state_r == bpd_pkg::ST_BASE) begin
      base_r <= ADDR_W'(cj_r) * ADDR_W'(PTS_X) + ADDR_W'(ci_r);
    end
    if (state_r == bpd_pkg::ST_RUN) begin
      mul_r       <= MUL_W'(mul_a) * MUL_W'(mul_b);
      wr_corner_r <= corner_addr;
    end
    if (out_load) begin
      out_read_index_r    <= rd_index_r;
      out_point_sum_r     <= rd_in_range_r ? bpd_pkg::SUM_W'(rd_data_r[ACC_BITS-1:0]) : '0;
      out_was_saturated_r <= rd_in_range_r && rd_data_r[ACC_BITS];
    end
  end

  // ---------------------------------------------------------------- grid memory
  always_ff @(posedge clk) begin
    if (wr_en) grid_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= grid_r[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_read_index    = out_read_index_r;
  assign out_point_sum     = out_point_sum_r;
  assign out_was_saturated = out_was_saturated_r;

  // ---------------------------------------------------------------- assertions
  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("grid read and write hit the same entry in one cycle");

  a_closed_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpd_pkg::ST_CLEAR) |-> !in_ready)
    else $error("input open during clearing pass");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (wr_data[ACC_BITS-1:0] == ACC_MAX)) |-> wr_data[ACC_BITS])
    else $error("full-scale sum written without saturation flag");

  a_corner_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpd_pkg::ST_BASE) |=> (state_r == bpd_pkg::ST_RUN && k_r == 2'd0))
    else $error("corner loop did not start at the first corner");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == bpd_pkg::ST_IDLE))
    else $error("read result not registered");

endmodule

`default_nettype wire
